// ===== src/image_rotate_right_angle_core_defines.svh =====
// image_rotate_right_angle_core_defines.svh
// Assertion macros used by the checker file.
`ifndef IMAGE_ROTATE_RIGHT_ANGLE_CORE_DEFINES_SVH
`define IMAGE_ROTATE_RIGHT_ANGLE_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define IRRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define IRRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/irrc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_pkg
// Types, codes and helpers of the right-angle image rotate core.
// ----------------------------------------------------------------------------
package irrc_pkg;

  localparam int NUM_CH = 3;
  localparam int PIX_W  = 24;
  localparam int DIM_W  = 9;

  localparam logic [1:0] FUNC_WRITE  = 2'd0;
  localparam logic [1:0] FUNC_READ   = 2'd1;
  localparam logic [1:0] FUNC_ROTATE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_ANGLE  = 2'd1;
  localparam logic [1:0] ST_NOT_SQUARE = 2'd2;

  localparam logic [1:0] CH_COUNT_RESET = 2'd3;

  localparam logic signed [10:0] ANG_0    = 11'sd0;
  localparam logic signed [10:0] ANG_P90  = 11'sd90;
  localparam logic signed [10:0] ANG_P180 = 11'sd180;
  localparam logic signed [10:0] ANG_P270 = 11'sd270;
  localparam logic signed [10:0] ANG_P360 = 11'sd360;
  localparam logic signed [10:0] ANG_N90  = -11'sd90;
  localparam logic signed [10:0] ANG_N180 = -11'sd180;
  localparam logic signed [10:0] ANG_N270 = -11'sd270;
  localparam logic signed [10:0] ANG_N360 = -11'sd360;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_READ,
    OP_ROTATE,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       row;
    logic [7:0]       col;
    logic [PIX_W-1:0] pix;
    logic [1:0]       status;
    logic [1:0]       quarter;
    logic [DIM_W-1:0] org_y;
    logic [DIM_W-1:0] org_x;
    logic [DIM_W-1:0] reg_h;
    logic [DIM_W-1:0] reg_w;
    logic [DIM_W-1:0] new_w;
    logic [DIM_W-1:0] new_h;
    logic [DIM_W-1:0] new_x2;
    logic [DIM_W-1:0] new_y2;
  } cmd_t;

  function automatic logic [PIX_W-1:0] chan_mask(input logic [1:0] cc);
    logic [PIX_W-1:0] m;
    case (cc)
      2'd3:    m = 24'hFFFFFF;
      2'd2:    m = 24'h00FFFF;
      default: m = 24'h0000FF;
    endcase
    return m;
  endfunction

endpackage

// ===== src/irrc_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_req_if
// Request channel: one operation per transaction.
// ----------------------------------------------------------------------------
interface irrc_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [7:0]         row;
  logic [7:0]         col;
  logic [23:0]        pixel_value;
  logic signed [10:0] angle;
  logic [8:0]         sel_x1;
  logic [8:0]         sel_y1;
  logic [8:0]         sel_x2;
  logic [8:0]         sel_y2;
  logic [8:0]         img_width;
  logic [8:0]         img_height;

  modport source (output valid, func, row, col, pixel_value, angle, sel_x1, sel_y1,
                  sel_x2, sel_y2, img_width, img_height, input ready);
  modport sink   (input valid, func, row, col, pixel_value, angle, sel_x1, sel_y1,
                  sel_x2, sel_y2, img_width, img_height, output ready);
endinterface

// ===== src/irrc_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_rsp_if
// Response channel: one result per transaction.
// ----------------------------------------------------------------------------
interface irrc_rsp_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_out;
  logic [1:0]  status;
  logic [8:0]  new_width;
  logic [8:0]  new_height;
  logic [8:0]  new_sel_x2;
  logic [8:0]  new_sel_y2;

  modport source (output valid, pixel_out, status, new_width, new_height, new_sel_x2,
                  new_sel_y2, input ready);
  modport sink   (input valid, pixel_out, status, new_width, new_height, new_sel_x2,
                  new_sel_y2, output ready);
endinterface

// ===== src/irrc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_front
// Decodes requests, checks angle and selection, queues commands (2 deep).
// ----------------------------------------------------------------------------
module irrc_front (
  input  logic            clk,
  input  logic            rst,
  irrc_req_if.sink        req,
  output irrc_pkg::cmd_t  cmd,
  output logic            cmd_valid,
  input  logic            cmd_ready
);

  irrc_pkg::cmd_t dec;
  logic           ang_ok;
  logic [1:0]     quarter;
  logic           square;
  logic           whole;
  logic           push;
  logic           pop;

  irrc_pkg::cmd_t queue [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  always_comb begin
    ang_ok  = 1'b1;
    quarter = 2'd0;
    case (req.angle)
      irrc_pkg::ANG_0, irrc_pkg::ANG_P360, irrc_pkg::ANG_N360: quarter = 2'd0;
      irrc_pkg::ANG_P90, irrc_pkg::ANG_N270:                   quarter = 2'd1;
      irrc_pkg::ANG_P180, irrc_pkg::ANG_N180:                  quarter = 2'd2;
      irrc_pkg::ANG_P270, irrc_pkg::ANG_N90:                   quarter = 2'd3;
      default: ang_ok = 1'b0;
    endcase
  end

  assign square = ({1'b0, req.sel_y2} + {1'b0, req.sel_x1}) ==
                  ({1'b0, req.sel_x2} + {1'b0, req.sel_y1});
  assign whole  = (req.sel_x1 == '0) && (req.sel_y1 == '0) &&
                  (req.sel_x2 == req.img_width) && (req.sel_y2 == req.img_height);

  always_comb begin
    dec         = '0;
    dec.op      = irrc_pkg::OP_NONE;
    dec.row     = req.row;
    dec.col     = req.col;
    dec.pix     = req.pixel_value;
    dec.status  = irrc_pkg::ST_OK;
    dec.quarter = quarter;
    dec.new_w   = req.img_width;
    dec.new_h   = req.img_height;
    dec.new_x2  = req.sel_x2;
    dec.new_y2  = req.sel_y2;
    case (req.func)
      irrc_pkg::FUNC_WRITE: dec.op = irrc_pkg::OP_WRITE;
      irrc_pkg::FUNC_READ:  dec.op = irrc_pkg::OP_READ;
      irrc_pkg::FUNC_ROTATE: begin
        if (!ang_ok) begin
          dec.status = irrc_pkg::ST_BAD_ANGLE;
        end else if (!square && !whole) begin
          dec.status = irrc_pkg::ST_NOT_SQUARE;
        end else if (quarter != 2'd0) begin
          if (square) begin
            if (req.sel_x2 > req.sel_x1) begin
              dec.op    = irrc_pkg::OP_ROTATE;
              dec.org_y = req.sel_y1;
              dec.org_x = req.sel_x1;
              dec.reg_h = req.sel_x2 - req.sel_x1;
              dec.reg_w = req.sel_x2 - req.sel_x1;
            end
          end else begin
            if (req.img_width != '0 && req.img_height != '0) begin
              dec.op    = irrc_pkg::OP_ROTATE;
              dec.reg_h = req.img_height;
              dec.reg_w = req.img_width;
            end
            if (quarter[0]) begin
              dec.new_w  = req.img_height;
              dec.new_h  = req.img_width;
              dec.new_x2 = req.img_height;
              dec.new_y2 = req.img_width;
            end
          end
        end
      end
      default: dec.op = irrc_pkg::OP_NONE;
    endcase
  end

  assign req.ready = (count != 2'd2);
  assign push      = req.valid && req.ready;
  assign cmd_valid = (count != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/irrc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_back
// Executes commands on the frame and scratch stores, holds the result.
// ----------------------------------------------------------------------------
module irrc_back #(
  parameter int MAX_DIM = 256
) (
  input  logic                       clk,
  input  logic                       rst,
  input  irrc_pkg::cmd_t             cmd,
  input  logic                       cmd_valid,
  output logic                       cmd_ready,
  input  logic [irrc_pkg::PIX_W-1:0] mask,
  irrc_rsp_if.source                 rsp
);

  localparam int CW    = $clog2(MAX_DIM);
  localparam int AW    = 2 * CW;
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_COPY,
    S_GAP,
    S_WRBK,
    S_DONE
  } state_t;

  state_t         state;
  irrc_pkg::cmd_t cur;
  logic [8:0]     r_cnt;
  logic [8:0]     c_cnt;
  logic           cp_v;
  logic [AW-1:0]  cp_addr;
  logic           wb_v;
  logic [AW-1:0]  wb_addr;

  logic                       pop;
  logic                       rsp_set;
  logic [8:0]                 lim_h;
  logic [8:0]                 lim_w;
  logic                       row_end;
  logic                       all_end;
  logic [8:0]                 sr;
  logic [8:0]                 sc;
  logic                       fr_we;
  logic [AW-1:0]              fr_waddr;
  logic [irrc_pkg::PIX_W-1:0] fr_wdata;
  logic [AW-1:0]              fr_raddr;
  logic [irrc_pkg::PIX_W-1:0] fr_rd;
  logic [AW-1:0]              sc_raddr;
  logic [irrc_pkg::PIX_W-1:0] sc_rd;
  logic [irrc_pkg::PIX_W-1:0] scratch [DEPTH];

  function automatic logic [AW-1:0] pix_addr(input logic [9:0] r, input logic [9:0] c);
    logic [CW+9:0] re;
    logic [CW+9:0] ce;
    re = {{CW{1'b0}}, r};
    ce = {{CW{1'b0}}, c};
    return {re[CW-1:0], ce[CW-1:0]};
  endfunction

  assign cmd_ready = (state == S_IDLE) && (!rsp.valid || rsp.ready);
  assign pop       = cmd_valid && cmd_ready;
  assign rsp_set   = (state == S_READ) || (state == S_DONE) ||
                     (pop && cmd.op != irrc_pkg::OP_READ && cmd.op != irrc_pkg::OP_ROTATE);

  assign lim_h   = (state == S_WRBK && cur.quarter[0]) ? cur.reg_w : cur.reg_h;
  assign lim_w   = (state == S_WRBK && cur.quarter[0]) ? cur.reg_h : cur.reg_w;
  assign row_end = (c_cnt == lim_w - 9'd1);
  assign all_end = row_end && (r_cnt == lim_h - 9'd1);

  always_comb begin
    case (cur.quarter)
      2'd1: begin
        sr = cur.reg_h - 9'd1 - c_cnt;
        sc = r_cnt;
      end
      2'd2: begin
        sr = cur.reg_h - 9'd1 - r_cnt;
        sc = cur.reg_w - 9'd1 - c_cnt;
      end
      default: begin
        sr = c_cnt;
        sc = cur.reg_w - 9'd1 - r_cnt;
      end
    endcase
  end

  assign sc_raddr = pix_addr({1'b0, sr}, {1'b0, sc});
  assign fr_raddr = (state == S_COPY) ?
                    pix_addr({1'b0, cur.org_y} + {1'b0, r_cnt},
                             {1'b0, cur.org_x} + {1'b0, c_cnt}) :
                    pix_addr({2'b00, cmd.row}, {2'b00, cmd.col});
  assign fr_we    = wb_v || (pop && cmd.op == irrc_pkg::OP_WRITE);
  assign fr_waddr = wb_v ? wb_addr : pix_addr({2'b00, cmd.row}, {2'b00, cmd.col});
  assign fr_wdata = wb_v ? sc_rd : cmd.pix;

  for (genvar i = 0; i < irrc_pkg::NUM_CH; i++) begin : g_lane
    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q;
    always_ff @(posedge clk) begin
      if (fr_we && mask[8*i]) begin
        mem[fr_waddr] <= fr_wdata[8*i +: 8];
      end
      rd_q <= mem[fr_raddr];
    end
    assign fr_rd[8*i +: 8] = rd_q;
  end

  always_ff @(posedge clk) begin
    if (cp_v) begin
      scratch[cp_addr] <= fr_rd;
    end
    sc_rd <= scratch[sc_raddr];
  end

  always_ff @(posedge clk) begin
    cp_addr <= pix_addr({1'b0, r_cnt}, {1'b0, c_cnt});
    wb_addr <= pix_addr({1'b0, cur.org_y} + {1'b0, r_cnt},
                        {1'b0, cur.org_x} + {1'b0, c_cnt});
    if (pop) begin
      cur <= cmd;
    end
    if (rst) begin
      state     <= S_IDLE;
      r_cnt     <= '0;
      c_cnt     <= '0;
      cp_v      <= 1'b0;
      wb_v      <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      cp_v <= (state == S_COPY);
      wb_v <= (state == S_WRBK);
      if (rsp_set) begin
        rsp.valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            rsp.pixel_out  <= '0;
            rsp.status     <= cmd.status;
            rsp.new_width  <= cmd.new_w;
            rsp.new_height <= cmd.new_h;
            rsp.new_sel_x2 <= cmd.new_x2;
            rsp.new_sel_y2 <= cmd.new_y2;
            r_cnt          <= '0;
            c_cnt          <= '0;
            case (cmd.op)
              irrc_pkg::OP_READ:   state <= S_READ;
              irrc_pkg::OP_ROTATE: state <= S_COPY;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_READ: begin
          rsp.pixel_out <= fr_rd & mask;
          state         <= S_IDLE;
        end
        S_COPY, S_WRBK: begin
          if (all_end) begin
            c_cnt <= '0;
            r_cnt <= '0;
            state <= (state == S_COPY) ? S_GAP : S_DONE;
          end else if (row_end) begin
            c_cnt <= '0;
            r_cnt <= r_cnt + 9'd1;
          end else begin
            c_cnt <= c_cnt + 9'd1;
          end
        end
        S_GAP:   state <= S_WRBK;
        S_DONE:  state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/image_rotate_right_angle_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_rotate_right_angle_core
// Frame store with pixel write/read and in-place right-angle rotation.
// Writes and refused or no-op rotates are answered from the idle state; a
// read is answered from S_READ, a rotate from S_DONE after copy and writeback.
// Throughput: writes one per cycle while responses are taken; reads and rotates
// hold the back end; a rotate walks the region through the single frame port.
// Reset clears control state and sets channel_count to 3; stores are not cleared.
// ----------------------------------------------------------------------------
module image_rotate_right_angle_core #(
  parameter int MAX_DIM = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       wr_en,
  input  logic [1:0] wr_data,
  irrc_req_if.sink   req,
  irrc_rsp_if.source rsp
);

  logic [1:0]     channel_count;
  irrc_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= irrc_pkg::CH_COUNT_RESET;
    end else if (wr_en) begin
      channel_count <= wr_data;
    end
  end

  irrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready)
  );

  irrc_back #(
    .MAX_DIM (MAX_DIM)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .mask      (irrc_pkg::chan_mask(channel_count)),
    .rsp       (rsp)
  );

endmodule

// ===== src/irrc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irrc_checker
// Port-level checks on the response channel, bound to the core.
// ----------------------------------------------------------------------------
`include "image_rotate_right_angle_core_defines.svh"

module irrc_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [23:0] rsp_pixel_out,
  input logic [1:0]  rsp_status
);

  `IRRC_ASSERT_IMP(a_status_code, rsp_valid, rsp_status != 2'd3, "bad status code")
  `IRRC_ASSERT_IMP(a_refused_no_pixel, rsp_valid && rsp_status != irrc_pkg::ST_OK, rsp_pixel_out == '0, "refused transaction carries pixel data")
  `IRRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_status), "stalled response changed")

endmodule

bind image_rotate_right_angle_core irrc_checker u_irrc_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_pixel_out (rsp.pixel_out),
  .rsp_status    (rsp.status)
);
